// ----- hw/rtl/chr_pkg.sv -----
// Types and codes shared by the command line history ring.
// Used by chr_ctrl, chr_dp and command_line_history_ring.
package chr_pkg;

  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_UP   = 2'd1;
  localparam logic [1:0] REQ_DOWN = 2'd2;
  localparam logic [1:0] REQ_READ = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_in;
  } req_t;

  typedef struct packed {
    logic       status;
    logic [7:0] char_out;
    logic       last;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_TERM,
    ST_COPY,
    ST_READ,
    ST_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic ring_rd;
    logic rd_cursor;
    logic idx_clr;
    logic idx_inc;
    logic stage_byte;
    logic empty_end;
    logic commit_start;
    logic stg_rd;
    logic ring_wr;
    logic commit_end;
    logic dup_end;
    logic cur_up;
    logic cur_down;
    logic out_load;
    logic out_status;
    logic out_byte;
    logic out_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       char_zero;
    logic       can_stage;
    logic       staged_empty;
    logic       up_ok;
    logic       down_ok;
    logic       cursor_live;
    logic       dup;
    logic       idx_last_copy;
    logic       idx_last_read;
    logic       rd_zero;
    logic       rsp_free;
  } stat_t;

endpackage

// ----- hw/rtl/chr_dp.sv -----
// Datapath of the history ring: ring and staging memories, slot and cursor
// registers, walk counter and the result register. Depends on chr_pkg.
module chr_dp
  import chr_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8,
  parameter int LINE_BYTES    = 64
) (
  input  logic  clk,
  input  logic  rst,
  input  req_t  req,
  input  cmd_t  cmd,
  output stat_t stat,
  output logic  rsp_valid,
  output rsp_t  rsp,
  input  logic  rsp_stall
);

  localparam int SW    = $clog2(HISTORY_DEPTH);
  localparam int FW    = $clog2(HISTORY_DEPTH + 1);
  localparam int LW    = $clog2(LINE_BYTES);
  localparam int DEPTH = HISTORY_DEPTH * LINE_BYTES;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0]    ring_mem [DEPTH];
  logic [7:0]    stg_mem  [LINE_BYTES];
  logic [7:0]    ring_rd_data;
  logic [7:0]    stg_rd_data;

  logic [SW-1:0] newest;
  logic [FW-1:0] filled;
  logic          cur_live;
  logic [SW-1:0] cur_idx;
  logic [LW-1:0] staged_len;
  logic          differs;
  logic [LW-1:0] idx;
  logic [7:0]    char_r;

  logic [LW-1:0] idx_next;
  logic [SW-1:0] cur_slot;
  logic [SW-1:0] newest_adv;
  logic [AW-1:0] ring_rd_addr;
  logic [AW-1:0] ring_wr_addr;
  logic [7:0]    rd_eff;
  logic          up_ok;

  function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s,
                                              input logic [LW-1:0] i);
    return AW'(s) * AW'(LINE_BYTES) + AW'(i);
  endfunction

  always_comb begin
    if (cmd.idx_clr) begin
      idx_next = '0;
    end else if (cmd.idx_inc) begin
      idx_next = idx + LW'(1);
    end else begin
      idx_next = idx;
    end
    // slot that the cursor selects, counted back from the newest
    if (newest >= cur_idx) begin
      cur_slot = newest - cur_idx;
    end else begin
      cur_slot = SW'({1'b0, newest} + (SW+1)'(HISTORY_DEPTH) - {1'b0, cur_idx});
    end
    newest_adv   = (newest == SW'(HISTORY_DEPTH - 1)) ? '0 : newest + SW'(1);
    ring_rd_addr = cmd.rd_cursor ? slot_addr(cur_slot, idx_next)
                                 : slot_addr(newest, staged_len);
    ring_wr_addr = slot_addr(newest, idx);
    // an empty history reads as zero bytes
    rd_eff       = (filled == '0) ? 8'd0 : ring_rd_data;
    up_ok        = (filled != '0) &&
                   (cur_live || ((FW'(cur_idx) + FW'(1)) < filled));
  end

  assign stat.req_type      = req.req_type;
  assign stat.char_zero     = (req.char_in == 8'd0);
  assign stat.can_stage     = (staged_len < LW'(LINE_BYTES - 1));
  assign stat.staged_empty  = (staged_len == '0);
  assign stat.up_ok         = up_ok;
  assign stat.down_ok       = !cur_live;
  assign stat.cursor_live   = cur_live;
  assign stat.dup           = (filled != '0) && !differs && (rd_eff == 8'd0);
  assign stat.idx_last_copy = (idx == LW'(LINE_BYTES - 1));
  assign stat.idx_last_read = (idx == LW'(LINE_BYTES - 2));
  assign stat.rd_zero       = (ring_rd_data == 8'd0);
  assign stat.rsp_free      = !rsp_valid || !rsp_stall;

  // memories
  always_ff @(posedge clk) begin
    if (cmd.stage_byte) begin
      stg_mem[staged_len] <= char_r;
    end
    if (cmd.stg_rd) begin
      stg_rd_data <= stg_mem[idx_next];
    end
    if (cmd.ring_wr) begin
      ring_mem[ring_wr_addr] <= (idx < staged_len) ? stg_rd_data : 8'd0;
    end
    if (cmd.ring_rd) begin
      ring_rd_data <= ring_mem[ring_rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      char_r <= req.char_in;
    end
    if (cmd.out_load) begin
      rsp.status   <= cmd.out_status;
      rsp.char_out <= cmd.out_byte ? ring_rd_data : 8'd0;
      rsp.last     <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newest     <= '0;
      filled     <= '0;
      cur_live   <= 1'b1;
      cur_idx    <= '0;
      staged_len <= '0;
      differs    <= 1'b0;
      idx        <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      idx <= idx_next;
      if (cmd.stage_byte) begin
        if (rd_eff != char_r) begin
          differs <= 1'b1;
        end
        staged_len <= staged_len + LW'(1);
      end
      if (cmd.empty_end) begin
        differs <= 1'b0;
      end
      if (cmd.commit_start) begin
        newest <= newest_adv;
      end
      if (cmd.commit_end || cmd.dup_end) begin
        cur_live   <= 1'b1;
        staged_len <= '0;
        differs    <= 1'b0;
      end
      if (cmd.commit_end && (filled != FW'(HISTORY_DEPTH))) begin
        filled <= filled + FW'(1);
      end
      if (cmd.cur_up && up_ok) begin
        if (cur_live) begin
          cur_live <= 1'b0;
          cur_idx  <= '0;
        end else begin
          cur_idx <= cur_idx + SW'(1);
        end
      end
      if (cmd.cur_down && !cur_live) begin
        if (cur_idx == '0) begin
          cur_live <= 1'b1;
        end else begin
          cur_idx <= cur_idx - SW'(1);
        end
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/chr_ctrl.sv -----
// Controller of the history ring: request decode and the sequencing of
// staging, commit copy and line read. Depends on chr_pkg.
module chr_ctrl
  import chr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;
  logic   pend, pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  assign req_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    pend_next  = pend;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          case (stat.req_type)
            REQ_ADD: begin
              if (stat.char_zero) begin
                if (stat.staged_empty) begin
                  cmd.empty_end = 1'b1;
                  pend_next     = 1'b0;
                  state_next    = ST_RESP;
                end else begin
                  cmd.ring_rd = 1'b1;
                  state_next  = ST_TERM;
                end
              end else if (stat.can_stage) begin
                cmd.ring_rd = 1'b1;
                state_next  = ST_ADD;
              end
              // drop bytes past the end of the staging line
            end
            REQ_UP: begin
              cmd.cur_up = 1'b1;
              pend_next  = stat.up_ok;
              state_next = ST_RESP;
            end
            REQ_DOWN: begin
              cmd.cur_down = 1'b1;
              pend_next    = stat.down_ok;
              state_next   = ST_RESP;
            end
            default: begin
              pend_next = 1'b0;
              if (stat.cursor_live) begin
                state_next = ST_RESP;
              end else begin
                cmd.idx_clr   = 1'b1;
                cmd.ring_rd   = 1'b1;
                cmd.rd_cursor = 1'b1;
                state_next    = ST_READ;
              end
            end
          endcase
        end
      end
      ST_ADD: begin
        cmd.stage_byte = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_TERM: begin
        if (stat.dup) begin
          cmd.dup_end = 1'b1;
          pend_next   = 1'b0;
          state_next  = ST_RESP;
        end else begin
          cmd.commit_start = 1'b1;
          cmd.idx_clr      = 1'b1;
          cmd.stg_rd       = 1'b1;
          state_next       = ST_COPY;
        end
      end
      ST_COPY: begin
        cmd.ring_wr = 1'b1;
        if (stat.idx_last_copy) begin
          cmd.commit_end = 1'b1;
          pend_next      = 1'b1;
          state_next     = ST_RESP;
        end else begin
          cmd.idx_inc = 1'b1;
          cmd.stg_rd  = 1'b1;
        end
      end
      ST_READ: begin
        // hold the fetched byte until the result register frees up
        if (stat.rsp_free) begin
          cmd.out_load = 1'b1;
          if (stat.rd_zero) begin
            cmd.out_last = 1'b1;
            state_next   = ST_IDLE;
          end else begin
            cmd.out_byte = 1'b1;
            if (stat.idx_last_read) begin
              pend_next  = 1'b0;
              state_next = ST_RESP;
            end else begin
              cmd.idx_inc   = 1'b1;
              cmd.ring_rd   = 1'b1;
              cmd.rd_cursor = 1'b1;
            end
          end
        end
      end
      ST_RESP: begin
        if (stat.rsp_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = pend;
          cmd.out_last   = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/command_line_history_ring.sv -----
// Command line history ring: ring of recent lines with a browse cursor.
// Top level; instantiates chr_ctrl and chr_dp, depends on chr_pkg.
//
// Request channel (req_valid / req_stall / req): one item per request.
//   Add with a non-zero byte stages it (no result); bytes past LINE_BYTES-1
//   are dropped. Add with a zero byte ends the line: an empty line or a
//   duplicate of the newest entry is not stored, any other line is stored
//   by the byte-wide copy from the staging memory into the ring memory,
//   with one result either way. Up and down give one result each.
//   Read gives one result per line byte, one a cycle after a single fetch
//   cycle, then a closing zero byte with last set.
// Result channel (rsp_valid / rsp_stall / rsp): a single result register
//   sits at the output. A request may be taken while a result waits; the
//   block holds whenever the next result finds the register still full, so
//   a stalled receiver stalls the request side only once the register fills.
// Reset clears slot count, newest slot, cursor (back to the live line) and
//   the staged line at once; the fill count keeps unwritten ring slots out
//   of reach, an empty history reads as zero, so no clearing pass is needed.
module command_line_history_ring
  import chr_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8,
  parameter int LINE_BYTES    = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  cmd_t  cmd;
  stat_t stat;

  chr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  chr_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .LINE_BYTES    (LINE_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .rsp_stall (rsp_stall)
  );

  // no item is taken while a line is being copied into the ring
  a_copy_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.ring_wr |-> req_stall)
    else $error("item accepted during commit copy");

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.rsp_free)
    else $error("result register overwritten");

  // a commit leaves the cursor on the live line and the staging empty
  a_commit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.commit_end |=> (stat.cursor_live && stat.staged_empty))
    else $error("commit did not reset cursor and staging");

  // no request is taken straight after a completed copy
  a_copy_then_resp: assert property (@(posedge clk) disable iff (rst)
    cmd.commit_end |=> !cmd.accept)
    else $error("request taken before the commit result");

endmodule
